### design/apc_pkg.sv
package apc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_SEQ_DEF = 16;

  localparam int TIME_W  = 32;
  localparam int SPEED_W = 24;
  localparam int LEN_W   = 16;
  localparam int FACC_W  = 17;
  localparam int RATE_W  = 24;
  localparam int FD_W    = 24;
  localparam int EL_W    = 24;
  localparam int TV_W    = 32;
  localparam int SEQ_W   = 4;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int T_W     = PROD_W - FRAC_BITS;
  localparam int DVD_W   = 34;
  localparam int DVS_W   = 33;

  localparam logic [SPEED_W-1:0] SPEED_MIN = 24'h800000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'h7fffff;
  localparam logic [RATE_W-1:0]  RATE_MAX  = 24'hffffff;
  localparam logic [FACC_W-1:0]  FADE_ONE  = 17'h10000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DEFINE = 2'd1,
    CMD_START  = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  localparam logic [1:0] PM_NONE     = 2'd0;
  localparam logic [1:0] PM_LOOP     = 2'd1;
  localparam logic [1:0] PM_PINGPONG = 2'd2;
  localparam logic [1:0] PM_ONESHOT  = 2'd3;

  localparam logic [1:0] POSE_NONE    = 2'd0;
  localparam logic [1:0] POSE_AT_TIME = 2'd1;
  localparam logic [1:0] POSE_BLEND   = 2'd2;
  localparam logic [1:0] POSE_CAPTURE = 2'd3;

  typedef enum logic [1:0] {
    JOB_RECIP = 2'd0,
    JOB_SET   = 2'd1,
    JOB_LOOP  = 2'd2,
    JOB_PP    = 2'd3
  } job_e;

  typedef struct packed {
    logic       capture;
    logic       define;
    logic       stop;
    logic       start;
    logic       set_time;
    logic       div_go;
    job_e       job;
    logic       mul_go;
    logic       mul_fade;
    logic       fade_step;
    logic       t_sum;
    logic       t_mode;
    logic       apply;
    logic       out_load;
    logic [1:0] pose;
    logic       acc;
  } apc_cmd_t;

  typedef struct packed {
    cmd_e       cmd;
    logic       full;
    logic       sq_bad;
    logic       stop_req;
    logic       stopped;
    logic       fade_on;
    logic       fd_zero;
    logic       rd_len_zero;
    logic       len_zero;
    logic       fade_ge_one;
    logic       run_ok;
    logic [1:0] mode;
    logic       div_done;
    logic       out_stall;
  } apc_stat_t;

endpackage

### design/apc_ram.sv
module apc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/apc_div.sv
module apc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [apc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [apc_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [apc_pkg::DVD_W-1:0]  quot_o,
  output logic [apc_pkg::DVS_W-1:0]  rem_o
);
  import apc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   rem_w;
  logic [DVS_W+1:0] diff;
  logic             sub_ok;

  // one quotient bit per cycle, restoring shift-subtract
  assign rem_w  = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = {1'b0, rem_w} - {2'b0, dvs_q};
  assign sub_ok = !diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= sub_ok ? diff[DVS_W-1:0] : rem_w[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], sub_ok};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

### design/apc_ctrl.sv
module apc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  apc_pkg::apc_stat_t st_i,
  output apc_pkg::apc_cmd_t  cmd_o
);
  import apc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_LOAD   = 11'b000_0000_0100,
    S_MULF   = 11'b000_0000_1000,
    S_FADE   = 11'b000_0001_0000,
    S_MULS   = 11'b000_0010_0000,
    S_TSUM   = 11'b000_0100_0000,
    S_TMODE  = 11'b000_1000_0000,
    S_DIV    = 11'b001_0000_0000,
    S_APPLY  = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  state_e     state_q, state_d;
  job_e       job_q, job_d;
  logic [1:0] pose_q, pose_d;
  logic       acc_q, acc_d;
  apc_cmd_t   cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    pose_d  = pose_q;
    acc_d   = acc_q;
    cmd     = '0;
    cmd.job  = job_q;
    cmd.pose = pose_q;
    cmd.acc  = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          pose_d      = POSE_NONE;
          acc_d       = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        unique case (st_i.cmd)
          CMD_DEFINE: begin
            if (st_i.full) acc_d = 1'b0;
            else cmd.define = 1'b1;
          end
          CMD_START: begin
            if (st_i.stop_req) cmd.stop = 1'b1;
            else if (st_i.sq_bad) acc_d = 1'b0;
            else state_d = S_LOAD;
          end
          CMD_SET: begin
            if (st_i.sq_bad) acc_d = 1'b0;
            else state_d = S_LOAD;
          end
          CMD_TICK: begin
            if (!st_i.stopped) state_d = st_i.fade_on ? S_MULF : S_MULS;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_LOAD: begin
        pose_d  = POSE_AT_TIME;
        state_d = S_FIN;
        if (st_i.cmd == CMD_START) begin
          cmd.start = 1'b1;
          if (!st_i.fd_zero) begin
            pose_d     = POSE_CAPTURE;
            cmd.div_go = 1'b1;
            cmd.job    = JOB_RECIP;
            job_d      = JOB_RECIP;
            state_d    = S_DIV;
          end
        end else begin
          cmd.set_time = 1'b1;
          if (!st_i.rd_len_zero) begin
            cmd.div_go = 1'b1;
            cmd.job    = JOB_SET;
            job_d      = JOB_SET;
            state_d    = S_DIV;
          end
        end
      end
      S_MULF: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_fade = 1'b1;
        state_d      = S_FADE;
      end
      S_FADE: begin
        cmd.fade_step = 1'b1;
        if (!st_i.fade_ge_one) begin
          pose_d  = POSE_BLEND;
          state_d = S_FIN;
        end else if (st_i.run_ok) begin
          state_d = S_MULS;
        end else begin
          pose_d  = POSE_AT_TIME;
          state_d = S_FIN;
        end
      end
      S_MULS: begin
        cmd.mul_go = 1'b1;
        state_d    = S_TSUM;
      end
      S_TSUM: begin
        cmd.t_sum = 1'b1;
        state_d   = S_TMODE;
      end
      S_TMODE: begin
        pose_d = POSE_AT_TIME;
        if ((st_i.mode == PM_LOOP || st_i.mode == PM_PINGPONG) && !st_i.len_zero) begin
          cmd.div_go = 1'b1;
          cmd.job    = (st_i.mode == PM_LOOP) ? JOB_LOOP : JOB_PP;
          job_d      = cmd.job;
          state_d    = S_DIV;
        end else begin
          cmd.t_mode = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_DIV: begin
        if (st_i.div_done) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!st_i.out_stall) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= JOB_RECIP;
      pose_q  <= POSE_NONE;
      acc_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      pose_q  <= pose_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### design/apc_dp.sv
module apc_dp #(
  parameter int MAX_SEQUENCES = apc_pkg::MAX_SEQ_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apc_pkg::apc_cmd_t             cmd_i,
  output apc_pkg::apc_stat_t            st_o,
  input  logic [1:0]                    mode_i,
  input  logic [apc_pkg::EL_W-1:0]      elapsed_i,
  input  logic [1:0]                    play_mode_i,
  input  logic [apc_pkg::SPEED_W-1:0]   play_speed_i,
  input  logic [apc_pkg::SEQ_W-1:0]     seq_index_i,
  input  logic [apc_pkg::LEN_W-1:0]     frame_count_i,
  input  logic [apc_pkg::FD_W-1:0]      fade_duration_i,
  input  logic [apc_pkg::TV_W-1:0]      time_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apc_pkg::TIME_W-1:0]    anim_time_o,
  output logic [15:0]                   blend_o,
  output logic [apc_pkg::SEQ_W-1:0]     active_seq_o,
  output logic [1:0]                    active_mode_o,
  output logic                          fading_o,
  output logic [1:0]                    pose_action_o,
  output logic [apc_pkg::SPEED_W-1:0]   current_speed_o,
  output logic                          accepted_o
);
  import apc_pkg::*;

  localparam int CW   = $clog2(MAX_SEQUENCES + 1);
  localparam int AW   = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int CMPW = (CW > SEQ_W) ? CW : SEQ_W;

  // captured item
  cmd_e                     cmd_q;
  logic signed [EL_W-1:0]   el_q;
  logic [1:0]               pm_q;
  logic signed [SPEED_W-1:0] sp_q;
  logic [SEQ_W-1:0]         sq_q;
  logic [LEN_W-1:0]         fc_q;
  logic [FD_W-1:0]          fd_q;
  logic signed [TV_W-1:0]   tv_q;

  // playback state
  logic [CW-1:0]            count_q;
  logic [SEQ_W-1:0]         seq_q;
  logic [1:0]               mode_q;
  logic                     fade_q;
  logic [LEN_W-1:0]         len_q;
  logic [TIME_W-1:0]        time_q;
  logic [SPEED_W-1:0]       speed_q;
  logic [FACC_W-1:0]        facc_q;
  logic [RATE_W-1:0]        rate_q;

  // work registers
  logic signed [PROD_W-1:0] prod_q;
  logic signed [T_W-1:0]    t_q;
  logic                     div_neg_q;
  logic [DVS_W-1:0]         div_m_q;

  logic                     out_valid_q;

  logic [LEN_W-1:0]         rd_len;
  logic [TIME_W-1:0]        lfix, rd_lfix;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [T_W-1:0]    delta;
  logic signed [T_W:0]      fsum;
  logic                     fade_ge_one;
  logic [FACC_W-1:0]        fsum_clamped;
  logic                     run_ok;
  logic signed [DVD_W-1:0]  tv_x, t_x;
  logic [DVD_W-1:0]         tv_abs, t_abs, dvd;
  logic [DVS_W-1:0]         dvs;
  logic                     dvs_neg;
  logic                     div_done;
  logic [DVD_W-1:0]         quot;
  logic [DVS_W-1:0]         rem, rr, pp_fold;
  logic [SPEED_W-1:0]       speed_neg;
  logic signed [T_W-1:0]    lfix_s;

  apc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEQUENCES), .AW(AW)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.define),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (fc_q),
    .raddr_i (AW'(sq_q)),
    .rdata_o (rd_len)
  );

  apc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign lfix    = {len_q, FRAC_BITS'(0)};
  assign rd_lfix = {rd_len, FRAC_BITS'(0)};
  assign lfix_s  = $signed(T_W'(lfix));

  assign mul_a = cmd_i.mul_fade ? $signed({1'b0, rate_q}) : $signed({speed_q[SPEED_W-1], speed_q});
  assign mul_b = $signed({el_q[EL_W-1], el_q});

  // floor of product / 2^FRAC_BITS
  assign delta = prod_q[FRAC_BITS +: T_W];

  assign fsum         = $signed({1'b0, T_W'(facc_q)}) + (T_W+1)'(delta);
  assign fade_ge_one  = !fsum[T_W] && (fsum[T_W-1:0] >= T_W'(FADE_ONE));
  assign fsum_clamped = fsum[T_W] ? '0 : fsum[FACC_W-1:0];
  assign run_ok       = (mode_q != PM_NONE) && (speed_q != '0);

  assign tv_x   = DVD_W'(tv_q);
  assign tv_abs = tv_x[DVD_W-1] ? DVD_W'(-tv_x) : DVD_W'(tv_x);
  assign t_x    = DVD_W'(t_q);
  assign t_abs  = t_x[DVD_W-1] ? DVD_W'(-t_x) : DVD_W'(t_x);

  always_comb begin
    case (cmd_i.job)
      JOB_RECIP: begin
        dvd     = DVD_W'(1) << (2 * FRAC_BITS);
        dvs     = DVS_W'(fd_q);
        dvs_neg = 1'b0;
      end
      JOB_SET: begin
        dvd     = tv_abs;
        dvs     = DVS_W'(rd_lfix);
        dvs_neg = tv_q[TV_W-1];
      end
      JOB_LOOP: begin
        dvd     = t_abs;
        dvs     = DVS_W'(lfix);
        dvs_neg = t_q[T_W-1];
      end
      default: begin
        dvd     = t_abs;
        dvs     = {lfix, 1'b0};
        dvs_neg = t_q[T_W-1];
      end
    endcase
  end

  // a negative operand wraps to modulus minus remainder
  assign rr        = (div_neg_q && rem != '0) ? div_m_q - rem : rem;
  assign pp_fold   = div_m_q - rr;
  assign speed_neg = (speed_q == SPEED_MIN) ? SPEED_MAX : SPEED_W'(-speed_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_e'(mode_i);
      el_q  <= elapsed_i;
      pm_q  <= play_mode_i;
      sp_q  <= play_speed_i;
      sq_q  <= seq_index_i;
      fc_q  <= frame_count_i;
      fd_q  <= fade_duration_i;
      tv_q  <= time_value_i;
    end
    if (cmd_i.mul_go) prod_q <= mul_a * mul_b;
    if (cmd_i.t_sum)  t_q    <= $signed({2'b0, time_q}) + delta;
    if (cmd_i.div_go) begin
      div_neg_q <= dvs_neg;
      div_m_q   <= dvs;
    end
    if (cmd_i.out_load) begin
      anim_time_o     <= time_q;
      blend_o         <= fade_q ? facc_q[15:0] : '0;
      active_seq_o    <= seq_q;
      active_mode_o   <= mode_q;
      fading_o        <= fade_q;
      pose_action_o   <= cmd_i.pose;
      current_speed_o <= speed_q;
      accepted_o      <= cmd_i.acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seq_q       <= '0;
      mode_q      <= PM_NONE;
      fade_q      <= 1'b0;
      len_q       <= '0;
      time_q      <= '0;
      speed_q     <= '0;
      facc_q      <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (cmd_i.define) count_q <= count_q + 1'b1;

      if (cmd_i.stop) begin
        mode_q <= PM_NONE;
        fade_q <= 1'b0;
        facc_q <= '0;
      end

      if (cmd_i.start) begin
        seq_q   <= sq_q;
        len_q   <= rd_len;
        speed_q <= sp_q;
        time_q  <= sp_q[SPEED_W-1] ? rd_lfix : '0;
        facc_q  <= '0;
        fade_q  <= (fd_q != '0);
        mode_q  <= (fd_q == '0 && sp_q == '0) ? PM_NONE : pm_q;
      end

      if (cmd_i.set_time) begin
        mode_q  <= PM_NONE;
        fade_q  <= 1'b0;
        facc_q  <= '0;
        speed_q <= '0;
        seq_q   <= sq_q;
        len_q   <= rd_len;
        time_q  <= '0;
      end

      if (cmd_i.fade_step) begin
        if (!fade_ge_one) begin
          facc_q <= fsum_clamped;
        end else begin
          fade_q <= 1'b0;
          facc_q <= '0;
          if (!run_ok) mode_q <= PM_NONE;
        end
      end

      if (cmd_i.t_mode) begin
        case (mode_q)
          PM_ONESHOT: begin
            if (t_q < 0) begin
              time_q <= '0;
              mode_q <= PM_NONE;
            end else if (t_q >= lfix_s) begin
              time_q <= lfix;
              mode_q <= PM_NONE;
            end else begin
              time_q <= t_q[TIME_W-1:0];
            end
          end
          PM_LOOP, PM_PINGPONG: time_q <= '0;
          default: time_q <= t_q[TIME_W-1:0];
        endcase
      end

      if (cmd_i.apply) begin
        case (cmd_i.job)
          JOB_RECIP: rate_q <= (|quot[DVD_W-1:RATE_W]) ? RATE_MAX : quot[RATE_W-1:0];
          JOB_SET, JOB_LOOP: time_q <= rr[TIME_W-1:0];
          default: begin
            // fold the second half back and reverse
            if (rr >= DVS_W'(lfix)) begin
              time_q  <= pp_fold[TIME_W-1:0];
              speed_q <= speed_neg;
            end else begin
              time_q <= rr[TIME_W-1:0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    st_o             = '0;
    st_o.cmd         = cmd_q;
    st_o.full        = (count_q == CW'(MAX_SEQUENCES));
    st_o.sq_bad      = (CMPW'(sq_q) >= CMPW'(count_q));
    st_o.stop_req    = (pm_q == PM_NONE) && (sp_q == '0);
    st_o.stopped     = (mode_q == PM_NONE) && !fade_q;
    st_o.fade_on     = fade_q;
    st_o.fd_zero     = (fd_q == '0);
    st_o.rd_len_zero = (rd_len == '0);
    st_o.len_zero    = (len_q == '0);
    st_o.fade_ge_one = fade_ge_one;
    st_o.run_ok      = run_ok;
    st_o.mode        = mode_q;
    st_o.div_done    = div_done;
    st_o.out_stall   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;

  a_fade_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    facc_q < FADE_ONE)
    else $error("fade accumulator reached one");

  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q <= lfix)
    else $error("time beyond sequence length");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SEQUENCES))
    else $error("sequence count overflow");

endmodule

### design/animation_playback_clock_top.sv
// One command at a time; each transfer in gives one transfer out.
// Define, stop, rejected commands and ticks while stopped: capture, decode and finish states, then the output register.
// Start without fade, set time in an empty sequence, ticks without wrap: also pass load or multiply and time states.
// Start with fade, set time and wrapping ticks: also wait for the 34-step divider.
// Next item is taken once its result is in the output register; a held result stalls it.
// Async reset clears all playback state; the length table holds no reset value.
module animation_playback_clock_top #(
  parameter int MAX_SEQUENCES = apc_pkg::MAX_SEQ_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [apc_pkg::EL_W-1:0]      elapsed_i,
  input  logic [1:0]                    play_mode_i,
  input  logic [apc_pkg::SPEED_W-1:0]   play_speed_i,
  input  logic [apc_pkg::SEQ_W-1:0]     seq_index_i,
  input  logic [apc_pkg::LEN_W-1:0]     frame_count_i,
  input  logic [apc_pkg::FD_W-1:0]      fade_duration_i,
  input  logic [apc_pkg::TV_W-1:0]      time_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apc_pkg::TIME_W-1:0]    anim_time_o,
  output logic [15:0]                   blend_o,
  output logic [apc_pkg::SEQ_W-1:0]     active_seq_o,
  output logic [1:0]                    active_mode_o,
  output logic                          fading_o,
  output logic [1:0]                    pose_action_o,
  output logic [apc_pkg::SPEED_W-1:0]   current_speed_o,
  output logic                          accepted_o
);
  import apc_pkg::*;

  apc_cmd_t  cmd;
  apc_stat_t st;

  apc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  apc_dp #(.MAX_SEQUENCES(MAX_SEQUENCES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .mode_i          (mode_i),
    .elapsed_i       (elapsed_i),
    .play_mode_i     (play_mode_i),
    .play_speed_i    (play_speed_i),
    .seq_index_i     (seq_index_i),
    .frame_count_i   (frame_count_i),
    .fade_duration_i (fade_duration_i),
    .time_value_i    (time_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .anim_time_o     (anim_time_o),
    .blend_o         (blend_o),
    .active_seq_o    (active_seq_o),
    .active_mode_o   (active_mode_o),
    .fading_o        (fading_o),
    .pose_action_o   (pose_action_o),
    .current_speed_o (current_speed_o),
    .accepted_o      (accepted_o)
  );

endmodule
